// File: design/sha256_hash_engine_defines.svh
// Assertion macros for the SHA-256 hash engine checkers.
`ifndef SHA256_HASH_ENGINE_DEFINES_SVH
`define SHA256_HASH_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define SHA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sha256 check failed");

// Next-cycle implication, disabled in reset.
`define SHA_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sha256 check failed");

`endif

// File: design/sha256_pkg.sv
// Shared types, constants and round functions of the SHA-256 hash engine.
`default_nettype none

package sha256_pkg;

  localparam logic [5:0] FILL_LAST  = 6'd63;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [5:0] ROUND_LAST = 6'd63;
  localparam logic [2:0] WORD_LAST  = 3'd7;
  localparam logic [7:0] PAD_BYTE   = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_INIT,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    SRC_MSG,
    SRC_PAD,
    SRC_ZERO,
    SRC_LEN
  } byte_src_t;

  typedef struct packed {
    logic      push;
    byte_src_t src;
    logic      load_vars;
    logic      round;
    logic      add_hash;
    logic      reset_hash;
    logic      clr_count;
    logic [5:0] rnd;
    logic [2:0] out_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
  } dp_stat_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] h_init(input logic [2:0] i);
    case (i)
      3'd0:    h_init = 32'h6a09e667;
      3'd1:    h_init = 32'hbb67ae85;
      3'd2:    h_init = 32'h3c6ef372;
      3'd3:    h_init = 32'ha54ff53a;
      3'd4:    h_init = 32'h510e527f;
      3'd5:    h_init = 32'h9b05688c;
      3'd6:    h_init = 32'h1f83d9ab;
      default: h_init = 32'h5be0cd19;
    endcase
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] r);
    case (r)
      6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
      6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
      6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
      6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7;  6'd63: round_k = 32'hc67178f2;
      default: round_k = 32'h0;
    endcase
  endfunction

endpackage

`default_nettype wire

// File: design/sha256_dp.sv
// SHA-256 datapath: block shift line, message schedule, round unit, chaining value.
`default_nettype none

module sha256_dp import sha256_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire dp_cmd_t     cmd,
  input  wire logic [7:0]  msg_byte,
  output dp_stat_t         stat,
  output logic [31:0]      digest_word
);

  logic [511:0] blk;          // word i at blk[511-32*i -: 32]
  logic [31:0]  v  [8];       // a..h
  logic [31:0]  hw [8];
  logic [60:0]  byte_count;
  logic [5:0]   fill;

  logic [63:0]  len_bits;
  logic [2:0]   len_sel;
  logic [7:0]   len_byte;
  logic [7:0]   push_val;
  logic [31:0]  w0, w1, w9, w14, new_w;
  logic [31:0]  t1, t2;

  assign len_bits = {byte_count, 3'b000};
  assign len_sel  = 3'd7 - fill[2:0];
  assign len_byte = 8'(len_bits >> {len_sel, 3'b000});

  always_comb begin
    case (cmd.src)
      SRC_MSG: push_val = msg_byte;
      SRC_PAD: push_val = PAD_BYTE;
      SRC_LEN: push_val = len_byte;
      default: push_val = 8'h00;
    endcase
  end

  assign w0    = blk[511:480];
  assign w1    = blk[479:448];
  assign w9    = blk[223:192];
  assign w14   = blk[63:32];
  assign new_w = ssig1(w14) + w9 + ssig0(w1) + w0;

  assign t1 = v[7] + bsig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
            + round_k(cmd.rnd) + w0;
  assign t2 = bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      blk <= {blk[503:0], push_val};
    end else if (cmd.round) begin
      blk <= {blk[479:0], new_w};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_vars) begin
      for (int i = 0; i < 8; i++) v[i] <= hw[i];
    end else if (cmd.round) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.reset_hash) begin
      for (int i = 0; i < 8; i++) hw[i] <= h_init(3'(i));
    end else if (cmd.add_hash) begin
      for (int i = 0; i < 8; i++) hw[i] <= hw[i] + v[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_count) begin
      byte_count <= '0;
    end else if (cmd.push && cmd.src == SRC_MSG) begin
      byte_count <= byte_count + 61'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.push) begin
      fill <= fill + 6'd1;
    end
  end

  assign stat.fill   = fill;
  assign digest_word = hw[cmd.out_idx];

endmodule

`default_nettype wire

// File: design/sha256_ctrl.sv
// SHA-256 controller: request handshakes, padding sequence, round and word counters.
`default_nettype none

module sha256_ctrl import sha256_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic        byte_present,
  input  wire logic        end_of_message,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [2:0]       word_index,
  output logic             last_word,
  input  wire dp_stat_t    stat,
  output dp_cmd_t          cmd
);

  state_t     state, state_next;
  logic [5:0] rnd, rnd_next;
  logic [2:0] idx, idx_next;
  logic       fin, fin_next;
  logic       pad_first, pad_first_next;
  logic       extra, extra_next;   // length goes in the block after the current one

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rnd       <= '0;
      idx       <= '0;
      fin       <= 1'b0;
      pad_first <= 1'b0;
      extra     <= 1'b0;
    end else begin
      state     <= state_next;
      rnd       <= rnd_next;
      idx       <= idx_next;
      fin       <= fin_next;
      pad_first <= pad_first_next;
      extra     <= extra_next;
    end
  end

  always_comb begin
    state_next     = state;
    rnd_next       = rnd;
    idx_next       = idx;
    fin_next       = fin;
    pad_first_next = pad_first;
    extra_next     = extra;
    s_tready       = 1'b0;
    m_tvalid       = 1'b0;
    last_word      = 1'b0;
    cmd            = '0;
    cmd.src        = SRC_MSG;
    cmd.rnd        = rnd;
    cmd.out_idx    = idx;

    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (end_of_message) begin
            fin_next       = 1'b1;
            pad_first_next = 1'b1;
            state_next     = ST_PAD;
          end
          if (byte_present) begin
            cmd.push = 1'b1;
            if (stat.fill == FILL_LAST) begin
              state_next = ST_INIT;
            end
          end
        end
      end
      ST_PAD: begin
        cmd.push = 1'b1;
        if (pad_first) begin
          cmd.src        = SRC_PAD;
          pad_first_next = 1'b0;
          extra_next     = (stat.fill >= LEN_POS);
        end else if (stat.fill >= LEN_POS && !extra) begin
          cmd.src = SRC_LEN;
        end else begin
          cmd.src = SRC_ZERO;
        end
        if (stat.fill == FILL_LAST) begin
          state_next = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd.load_vars = 1'b1;
        rnd_next      = '0;
        state_next    = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        rnd_next  = rnd + 6'd1;
        if (rnd == ROUND_LAST) begin
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd.add_hash = 1'b1;
        if (!fin) begin
          state_next = ST_IDLE;
        end else if (pad_first || extra) begin
          extra_next = 1'b0;
          state_next = ST_PAD;
        end else begin
          idx_next   = '0;
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        m_tvalid  = 1'b1;
        last_word = (idx == WORD_LAST);
        if (m_tready) begin
          if (idx == WORD_LAST) begin
            cmd.reset_hash = 1'b1;
            cmd.clr_count  = 1'b1;
            fin_next       = 1'b0;
            state_next     = ST_IDLE;
          end else begin
            idx_next = idx + 3'd1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign word_index = idx;

endmodule

`default_nettype wire

// File: design/sha256_hash_engine.sv
// Top level of the SHA-256 hash engine: controller plus datapath.
//
//  channel  | direction | signals                          | content
//  ---------+-----------+----------------------------------+---------------------------------
//  s_*      | in        | tvalid tready tdata tuser tlast  | message byte, byte flag, end mark
//  m_*      | out       | tvalid tready tdata tuser tlast  | digest word, word index, last
//
// Message bytes are taken one per cycle while idle; each full 64-byte block then runs in the
// single round unit (load, 64 rounds, chaining add).
// An end request adds up to 72 padding bytes plus one or two block compressions, then
// eight digest words. Input is taken only in the idle state.
// A stalled output holds the word; reset restores the initial hash and clears counts.
`default_nettype none

module sha256_hash_engine import sha256_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] msg_byte
  input  wire logic        s_tuser,   // [0] byte_present
  input  wire logic        s_tlast,   // end_of_message
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [31:0] digest_word
  output logic [2:0]       m_tuser,   // [2:0] word_index
  output logic             m_tlast    // last_word
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sha256_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .byte_present   (s_tuser),
    .end_of_message (s_tlast),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .word_index     (m_tuser),
    .last_word      (m_tlast),
    .stat           (stat),
    .cmd            (cmd)
  );

  sha256_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .msg_byte    (s_tdata),
    .stat        (stat),
    .digest_word (m_tdata)
  );

endmodule

`default_nettype wire

// File: design/sha256_chk.sv
// Port-level checker for the SHA-256 hash engine and its bind.
`default_nettype none
`include "sha256_hash_engine_defines.svh"

module sha256_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [7:0]  s_tdata,
  input wire logic        s_tuser,
  input wire logic        s_tlast,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic [2:0]  m_tuser,
  input wire logic        m_tlast
);

  `SHA_ASSERT_IMP(a_no_input_during_digest, clk, rst, m_tvalid, !s_tready)
  `SHA_ASSERT_IMP(a_last_on_word7, clk, rst, m_tvalid, m_tlast == (m_tuser == 3'd7))
  `SHA_ASSERT_NXT(a_index_steps, clk, rst, m_tvalid && m_tready && !m_tlast, m_tvalid && (m_tuser == $past(m_tuser) + 3'd1))
  `SHA_ASSERT_NXT(a_idle_after_digest, clk, rst, m_tvalid && m_tready && m_tlast, s_tready && !m_tvalid)
  `SHA_ASSERT_NXT(a_stall_holds, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind sha256_hash_engine sha256_chk u_chk (.*);

`default_nettype wire
